// ----- rtl/assert_macros.svh -----
// Assertion macros for the send window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property sampled on clk, disabled while in reset
`define RSW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// assert an implication on clk, disabled while in reset
`define RSW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// ----- rtl/rsw_pkg.sv -----
// Package with types, constants and helpers for the send window.
package rsw_pkg;
	localparam int unsigned HISTORY_DEF = 16;
	localparam logic [62:0] I64MAX = {63{1'b1}};

	typedef enum logic [2:0] {
		OP_RESET   = 3'd0,
		OP_RESERVE = 3'd1,
		OP_TAKE    = 3'd2,
		OP_TICK    = 3'd3,
		OP_ACKNACK = 3'd4,
		OP_LOST    = 3'd5
	} op_t;

	localparam logic [1:0] REG_SLOT_BYTES = 2'd0;
	localparam logic [1:0] REG_HDR_OFF    = 2'd1;
	localparam logic [1:0] REG_HB_IVL     = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] message_size;
		logic [62:0] now_ms;
		logic [15:0] first_unacked_seq;
		logic [15:0] lost_mask;
		logic [15:0] nack_cursor;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] seq_out;
		logic [3:0]  slot_index;
		logic [15:0] write_offset;
		logic [15:0] slot_length;
		logic [15:0] hb_first_unacked;
		logic [15:0] hb_last_unacked;
		logic [15:0] busy_ack_seq;
		logic        busy_res;
	} out_item_t;

	// configuration registers handed to the core
	typedef struct packed {
		logic [15:0] slot_bytes;
		logic [7:0]  empty_len;
		logic [15:0] hb_interval;
	} cfg_t;

	function automatic logic seq_le(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = b - a;
		return !d[15];
	endfunction

	function automatic logic seq_lt(input logic [15:0] a, input logic [15:0] b);
		return (a != b) && seq_le(a, b);
	endfunction
endpackage

// ----- rtl/reliable_send_window.sv -----
// Each operation runs through its own states; a reserve that opens a new slot and a tick
// that fires a heartbeat go on through S_TICK2, an acknack walks the slots past the old
// acknowledgement, a lost search walks the sent slots, and the reset operation sweeps every
// slot again. One item at a time: the next is taken only after the last result is transferred.
// Reset: asynchronous, active low; then a sweep loads every slot
// with the empty slot length before the first item is taken.
module reliable_send_window import rsw_pkg::*; #(
	parameter int unsigned HISTORY = HISTORY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);
`include "assert_macros.svh"
	cfg_t cfg;
	logic busy_chk;

	assign pready = 1'b1;
	assign busy_chk = seq_lt(out_data.busy_ack_seq, out_data.hb_last_unacked);

	rsw_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	rsw_core #(.HISTORY(HISTORY)) u_core (
		.clk, .arst_n, .cfg, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data
	);

	`RSW_ASSERT(a_no_overlap, !(in_ready && out_valid), "ready while result pending")
	`RSW_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
	`RSW_ASSERT_IMP(a_busy, out_valid, out_data.busy_res == busy_chk, "busy flag mismatch")
endmodule

// ----- rtl/rsw_regs.sv -----
// APB configuration registers of the send window.
module rsw_regs import rsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);
	logic [15:0] slot_bytes_q;
	logic [7:0]  hdr_q;
	logic [15:0] ivl_q;
	logic [1:0]  idx;

	assign idx = paddr[3:2];

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= 16'd512;
			hdr_q        <= 8'd8;
			ivl_q        <= 16'd100;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_SLOT_BYTES: slot_bytes_q <= pwdata[15:0];
				REG_HDR_OFF:    hdr_q        <= pwdata[7:0];
				REG_HB_IVL:     ivl_q        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_SLOT_BYTES: prdata = {16'd0, slot_bytes_q};
			REG_HDR_OFF:    prdata = {24'd0, hdr_q};
			REG_HB_IVL:     prdata = {16'd0, ivl_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = '{slot_bytes: slot_bytes_q, empty_len: hdr_q, hb_interval: ivl_q};
endmodule

// ----- rtl/rsw_core.sv -----
// Sequencer of the send window: walks slots one per cycle through a shared unit.
module rsw_core import rsw_pkg::*; #(
	parameter int unsigned HISTORY = HISTORY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int unsigned SW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int unsigned CW = $clog2(2 * HISTORY + 17) + 1;
	localparam logic [CW-1:0] LIM2H = CW'(2 * HISTORY);
	localparam logic [CW-1:0] LIMAK = CW'(16 + 2 * HISTORY);
	localparam logic [15:0] HIST16 = 16'(HISTORY);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RES, S_TAKE, S_TICK, S_TICK2, S_ACK1, S_ACK2, S_LOST, S_CLR,
		S_FIN, S_OUT
	} state_t;

	state_t state_q;
	in_item_t it_q;
	out_item_t res_q;
	logic [15:0] fill_q [HISTORY];
	logic [15:0] lw_q, ls_q, la_q;
	logic [62:0] nhb_q;
	logic armed_q, resend_q;
	logic [5:0] bexp_q;
	logic [CW-1:0] cnt_q, lim_q;
	logic [15:0] base_q;
	logic [SW-1:0] clr_q;
	logic found_q;
	logic [62:0] inc_q;

	// shared slot unit: one slot read per cycle at a sequence chosen by the sequencer
	logic [15:0] walk_seq;
	logic [SW-1:0] walk_slot;
	logic [15:0] walk_len;
	assign walk_seq  = base_q + 16'(cnt_q);
	assign walk_slot = SW'(walk_seq % HISTORY);
	assign walk_len  = fill_q[walk_slot];

	// reserve helpers
	logic [SW-1:0] cur_slot;
	logic [15:0] cur_len;
	logic [17:0] cur_fut, hdr_fut;
	logic [15:0] nx_w;
	assign cur_slot = SW'(lw_q % HISTORY);
	assign cur_len  = fill_q[cur_slot];
	assign cur_fut  = 18'(cur_len) + 18'((cur_len[1:0] != 2'd0) ? 3'd4 - 3'(cur_len[1:0]) : 3'd0)
		+ 18'(it_q.message_size);
	assign hdr_fut  = 18'(cfg.empty_len) + 18'(it_q.message_size);
	assign nx_w     = lw_q + 16'd1;
	logic [15:0] hdr16;
	assign hdr16 = 16'(cfg.empty_len);

	// heartbeat helpers
	logic [5:0] bexp_n, sh;
	logic [63:0] hsum;
	logic [62:0] diff, incm;
	assign bexp_n = bexp_q + 6'd1;
	assign sh     = (bexp_n == 6'd63) ? 6'd0 : bexp_n;
	assign diff   = it_q.now_ms - nhb_q;
	assign incm   = (diff > inc_q) ? diff : inc_q;
	assign hsum   = {1'b0, nhb_q} + {1'b0, incm};

	logic [62:0] arm_t;
	logic [63:0] arm_sum;
	assign arm_sum = {1'b0, it_q.now_ms} + 64'(cfg.hb_interval);
	assign arm_t   = arm_sum[63] ? I64MAX : arm_sum[62:0];

	logic [15:0] lsn;
	logic [15:0] acked;
	assign lsn   = ls_q + 16'd1;
	assign acked = it_q.first_unacked_seq - 16'd1;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			lw_q     <= '0;
			ls_q     <= 16'hFFFF;
			la_q     <= 16'hFFFF;
			nhb_q    <= I64MAX;
			armed_q  <= 1'b0;
			bexp_q   <= '0;
			resend_q <= 1'b0;
			cnt_q    <= '0;
			lim_q    <= '0;
			base_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				// sweep slots back to the empty length
				S_CLR: begin
					fill_q[clr_q] <= hdr16;
					if (clr_q == SW'(HISTORY - 1)) begin
						state_q <= found_q ? S_FIN : S_IDLE;
						found_q <= 1'b0;
					end
					clr_q <= clr_q + SW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						it_q    <= in_data;
						res_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					unique case (it_q.operation)
						OP_RESET: begin
							lw_q <= '0; ls_q <= 16'hFFFF; la_q <= 16'hFFFF;
							nhb_q <= I64MAX; armed_q <= 1'b0; bexp_q <= '0;
							resend_q <= 1'b0; clr_q <= '0; found_q <= 1'b1;
							state_q <= S_CLR;
						end
						OP_RESERVE: state_q <= S_RES;
						OP_TAKE:    state_q <= S_TAKE;
						OP_TICK:    state_q <= S_TICK;
						OP_ACKNACK: begin
							base_q  <= la_q + 16'd1;
							cnt_q   <= '0;
							lim_q   <= ((acked - la_q) < 16'(LIM2H)) ? CW'(acked - la_q) : LIM2H;
							state_q <= S_ACK1;
						end
						OP_LOST: begin
							res_q.seq_out <= it_q.nack_cursor;
							if (!resend_q) state_q <= S_FIN;
							else if ((ls_q - it_q.nack_cursor) == 16'd0 ||
								(ls_q - it_q.nack_cursor) > 16'h8000) begin
								res_q.seq_out <= it_q.nack_cursor + 16'd1;
								resend_q <= 1'b0;
								state_q <= S_FIN;
							end else begin
								base_q  <= it_q.nack_cursor + 16'd1;
								cnt_q   <= '0;
								lim_q   <= ((ls_q - it_q.nack_cursor) < 16'(LIM2H)) ?
									CW'(ls_q - it_q.nack_cursor) : LIM2H;
								state_q <= S_LOST;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_RES: begin
					state_q <= S_FIN;
					if (cur_fut <= 18'(cfg.slot_bytes)) begin
						if (seq_le(lw_q, la_q + HIST16)) begin
							fill_q[cur_slot] <= cur_fut[17:16] != 2'd0 ? 16'hFFFF : cur_fut[15:0];
							res_q.ok <= 1'b1; res_q.seq_out <= lw_q;
							res_q.slot_index <= 4'(cur_slot);
							res_q.write_offset <= cur_len;
							res_q.slot_length <= cur_fut[17:16] != 2'd0 ? 16'hFFFF : cur_fut[15:0];
						end
					end else if (hdr_fut <= 18'(cfg.slot_bytes) && seq_le(nx_w, la_q + HIST16)) begin
						// opened slot holds header_offset; its alignment pad is added in S_TICK2
						lw_q <= nx_w;
						base_q <= nx_w;
						cnt_q <= '0;
						state_q <= S_TICK2;
						found_q <= 1'b1;
					end
				end
				S_TAKE: begin
					res_q.seq_out <= lsn;
					res_q.slot_index <= 4'(SW'(lsn % HISTORY));
					res_q.slot_length <= fill_q[SW'(lsn % HISTORY)];
					if (seq_le(lsn, lw_q) && fill_q[SW'(lsn % HISTORY)] > hdr16 &&
						(ls_q - la_q) != HIST16) begin
						res_q.ok <= 1'b1;
						ls_q <= lsn;
						if (lsn == lw_q) lw_q <= lw_q + 16'd1;
					end
					state_q <= S_FIN;
				end
				S_TICK: begin
					state_q <= S_FIN;
					if (seq_lt(la_q, ls_q)) begin
						if (!armed_q) begin
							nhb_q <= arm_t; armed_q <= 1'b1; bexp_q <= 6'd1;
						end else if (it_q.now_ms >= nhb_q) begin
							bexp_q <= bexp_n;
							inc_q <= ((63'(cfg.hb_interval) << sh) >> sh) != 63'(cfg.hb_interval) ?
								I64MAX : (63'(cfg.hb_interval) << sh);
							found_q <= 1'b0;
							state_q <= S_TICK2;
						end
					end else nhb_q <= I64MAX;
				end
				// second tick state: saturating add; also finishes a reserve into a new slot
				S_TICK2: begin
					state_q <= S_FIN;
					if (found_q) begin
						fill_q[walk_slot] <= cur_fut[17:16] != 2'd0 ? 16'hFFFF : cur_fut[15:0];
						res_q.ok <= 1'b1; res_q.seq_out <= lw_q;
						res_q.slot_index <= 4'(walk_slot);
						res_q.write_offset <= cur_len;
						res_q.slot_length <= cur_fut[17:16] != 2'd0 ? 16'hFFFF : cur_fut[15:0];
						found_q <= 1'b0;
					end else begin
						nhb_q <= hsum[63] ? I64MAX : hsum[62:0];
						res_q.ok <= 1'b1;
					end
				end
				// free acknowledged slots
				S_ACK1: begin
					if (cnt_q < lim_q) begin
						fill_q[walk_slot] <= hdr16;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						la_q <= acked;
						base_q <= acked + 16'd1;
						cnt_q <= '0;
						lim_q <= ((ls_q - acked) < 16'(LIMAK)) ? CW'(ls_q - acked) : LIMAK;
						state_q <= S_ACK2;
					end
				end
				// mark lost ones, free the rest
				S_ACK2: begin
					if (cnt_q < lim_q) begin
						if (cnt_q < CW'(16) && it_q.lost_mask[cnt_q[3:0]]) resend_q <= 1'b1;
						else fill_q[walk_slot] <= hdr16;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						armed_q <= 1'b0; bexp_q <= '0;
						res_q.ok <= resend_q; res_q.seq_out <= la_q;
						state_q <= S_FIN;
					end
				end
				// search the next lost slot
				S_LOST: begin
					if (cnt_q < lim_q) begin
						if (walk_len != hdr16) begin
							res_q.ok <= 1'b1; res_q.seq_out <= walk_seq;
							res_q.slot_index <= 4'(walk_slot);
							res_q.slot_length <= walk_len;
							state_q <= S_FIN;
						end
						cnt_q <= cnt_q + CW'(1);
					end else begin
						res_q.seq_out <= it_q.nack_cursor + (ls_q - it_q.nack_cursor) + 16'd1;
						resend_q <= 1'b0;
						state_q <= S_FIN;
					end
				end
				// capture the window position after the operation
				S_FIN: begin
					res_q.hb_first_unacked <= la_q + 16'd1;
					res_q.hb_last_unacked  <= ls_q;
					res_q.busy_ack_seq     <= la_q;
					res_q.busy_res         <= seq_lt(la_q, ls_q);
					state_q <= S_OUT;
				end
				// hold the result until its transfer
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
